// ===== rtl/core/swtm_pkg.sv =====
package swtm_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS       = 16;
   localparam int OUT_W             = 16;
   localparam int FILL_W            = 6;
   localparam int CFG_W             = 6;
   localparam int WINDOW_MAX_DEF    = 32;
   localparam int WINDOW_SIZE_RESET = 8;

   // item kinds carried on req_tuser
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear;
      logic cfg_write;
      logic rd_old;
      logic update;
      logic div_start;
      logic div_trim;
      logic scan_start;
      logic scan_step;
      logic trim_prep;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trim_needed;
      logic scan_last;
      logic div_idle;
   } status_type;

endpackage

// ===== rtl/core/swtm_ram.sv =====
module swtm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/swtm_div.sv =====
module swtm_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             idle,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   shifted;
   logic             fits;

   // one quotient bit a step, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      if (fits) begin
         rem_in = DEN_W'(shifted - {1'b0, den_ff});
      end else begin
         rem_in = DEN_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign idle = !busy_ff && !done_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/swtm_datapath.sv =====
module swtm_datapath #(
   parameter int WINDOW_MAX = swtm_pkg::WINDOW_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  swtm_pkg::cmd_type            cmd,
   output swtm_pkg::status_type         status,
   input  logic [swtm_pkg::CFG_W-1:0]   csr_size,
   input  logic [15:0]                  req_sample,
   output logic [swtm_pkg::OUT_W-1:0]   rsp_mean,
   output logic [swtm_pkg::OUT_W-1:0]   rsp_trimmed,
   output logic [swtm_pkg::FILL_W-1:0]  rsp_filled
);

   localparam int SB    = swtm_pkg::SAMPLE_BITS;
   localparam int OW    = swtm_pkg::OUT_W;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int POS_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = SB + CNT_W;
   localparam int NUM_W = SUM_W + 2;
   localparam int DEN_W = CNT_W + 1;

   logic [swtm_pkg::CFG_W-1:0] size_ff;
   logic [CNT_W-1:0]           eff_size;
   logic [SB-1:0]              sample_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [POS_W-1:0]           pos_ff;
   logic [CNT_W-1:0]           pos_nxt;
   logic [CNT_W-1:0]           fill_m2;
   logic [SB-1:0]              old_val;
   logic [CNT_W-1:0]           scan_idx_ff;
   logic                       cmp_vld_ff;
   logic                       cmp_first_ff;
   logic [SB-1:0]              lo_ff;
   logic [SB-1:0]              hi_ff;
   logic [SUM_W-1:0]           trim_n_ff;
   logic                       sel_trim_ff;
   logic [OW-1:0]              mean_ff;
   logic [OW-1:0]              trim_ff;
   logic [OW-1:0]              out_mean_ff;
   logic [OW-1:0]              out_trim_ff;
   logic [swtm_pkg::FILL_W-1:0] out_fill_ff;

   logic                       ram_re;
   logic [POS_W-1:0]           ram_raddr;
   logic [SB-1:0]              ram_rdata;
   logic [NUM_W-1:0]           div_num;
   logic [DEN_W-1:0]           div_den;
   logic                       div_idle;
   logic                       div_done;
   logic [NUM_W-1:0]           div_quo;
   logic [OW-1:0]              quo_sat;

   // window size zero acts as one, oversize saturates
   always_comb begin
      if (size_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (32'(size_ff) > WINDOW_MAX) begin
         eff_size = CNT_W'(WINDOW_MAX);
      end else begin
         eff_size = CNT_W'(size_ff);
      end
   end

   // slots are unwritten until the window is full
   assign old_val = (fill_ff == eff_size) ? ram_rdata : '0;
   assign pos_nxt = CNT_W'(pos_ff) + CNT_W'(1);
   assign fill_m2 = fill_ff - CNT_W'(2);

   assign ram_re    = cmd.rd_old || cmd.scan_step;
   assign ram_raddr = cmd.rd_old ? pos_ff : scan_idx_ff[POS_W-1:0];

   swtm_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW_MAX)
   ) u_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (pos_ff),
      .wdata (sample_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // round half up: (2n + d) / (2d)
   always_comb begin
      if (cmd.div_trim) begin
         div_num = (NUM_W'(trim_n_ff) << 1) + NUM_W'(fill_m2);
         div_den = {fill_m2, 1'b0};
      end else begin
         div_num = (NUM_W'(sum_ff) << 1) + NUM_W'(fill_ff);
         div_den = {fill_ff, 1'b0};
      end
   end

   swtm_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .idle  (div_idle),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign quo_sat = (|div_quo[NUM_W-1:OW]) ? '1 : div_quo[OW-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= swtm_pkg::CFG_W'(swtm_pkg::WINDOW_SIZE_RESET);
         sum_ff     <= '0;
         fill_ff    <= '0;
         pos_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_step;
         if (cmd.cfg_write) begin
            size_ff <= csr_size;
         end
         if (cmd.cfg_write || cmd.clear) begin
            sum_ff  <= '0;
            fill_ff <= '0;
            pos_ff  <= '0;
         end else if (cmd.update) begin
            sum_ff <= sum_ff - SUM_W'(old_val) + SUM_W'(sample_ff);
            if (pos_nxt >= eff_size) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= POS_W'(pos_nxt);
            end
            if (fill_ff < eff_size) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= SB'(req_sample);
      end
      if (cmd.scan_start) begin
         scan_idx_ff  <= '0;
         cmp_first_ff <= 1'b1;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + CNT_W'(1);
      end
      if (cmp_vld_ff) begin
         cmp_first_ff <= 1'b0;
         if (cmp_first_ff || ram_rdata < lo_ff) begin
            lo_ff <= ram_rdata;
         end
         if (cmp_first_ff || ram_rdata > hi_ff) begin
            hi_ff <= ram_rdata;
         end
      end
      if (cmd.trim_prep) begin
         trim_n_ff <= sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff);
      end
      if (cmd.div_start) begin
         sel_trim_ff <= cmd.div_trim;
      end
      if (cmd.clear) begin
         mean_ff <= '0;
         trim_ff <= '0;
      end else if (div_done) begin
         trim_ff <= quo_sat;
         if (!sel_trim_ff) begin
            mean_ff <= quo_sat;
         end
      end
      if (cmd.out_load) begin
         out_mean_ff <= mean_ff;
         out_trim_ff <= trim_ff;
         out_fill_ff <= swtm_pkg::FILL_W'(fill_ff);
      end
   end

   assign status.trim_needed = fill_ff > CNT_W'(2);
   assign status.scan_last   = scan_idx_ff == fill_ff - CNT_W'(1);
   assign status.div_idle    = div_idle;

   assign rsp_mean    = out_mean_ff;
   assign rsp_trimmed = out_trim_ff;
   assign rsp_filled  = out_fill_ff;

endmodule

// ===== rtl/core/swtm_ctrl.sv =====
module swtm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_kind,
   output logic                 req_tready,
   input  logic                 csr_tvalid,
   output logic                 csr_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  swtm_pkg::status_type status,
   output swtm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN,
      ST_SCAN,
      ST_DRAIN,
      ST_TPREP,
      ST_TDIV,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      out_free;

   assign csr_tready = state_ff == ST_IDLE;
   assign req_tready = (state_ff == ST_IDLE) && !csr_tvalid;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.cfg_write = csr_tvalid;
            if (req_fire) begin
               cmd.accept = 1'b1;
               if (req_kind == swtm_pkg::KIND_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  cmd.rd_old = 1'b1;
                  state_in   = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MEAN;
         end
         ST_MEAN: begin
            cmd.div_start  = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = status.trim_needed ? ST_SCAN : ST_WAIT;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_TPREP;
         end
         ST_TPREP: begin
            cmd.trim_prep = 1'b1;
            if (status.div_idle) begin
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_trim  = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_idle) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/sliding_window_trimmed_mean_core.sv =====
// sliding window mean and trimmed mean of unsigned 16-bit samples
//
// req channel: one beat per item; tuser = kind (0 sample, 1 clear), tdata = sample
// rsp channel: one beat per item with the rounded mean, the rounded mean without
// the smallest and largest filled slot, and the number of filled slots
// csr channel: writes the window size (low 6 bits of csr_tdata) and empties the
// window; it is taken only while the core is idle
//
// a clear goes straight to the output stage. a sample reads the slot it replaces,
// updates the sum and starts the serial divider (one quotient bit a cycle, 24 bits
// at default size) on the mean; with three or more filled slots the min/max scan
// reads one window slot a cycle through the single ram read port while that
// division runs, and the divider then runs once more on the trimmed mean. one
// item is worked on at a time; with a ready receiver the next req beat can go on
// the edge of the rsp beat
// reset empties the window and sets the window size to 8; no clearing pass runs.
// a stalled receiver keeps the finished result in the output register; one more item
// is taken, and its result waits in the datapath until the register frees
module sliding_window_trimmed_mean_core #(
   parameter int WINDOW_MAX = swtm_pkg::WINDOW_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] mean, [31:16] trimmed_mean, [37:32] filled

   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // [5:0] window_size
);

   swtm_pkg::cmd_type    cmd;
   swtm_pkg::status_type status;

   logic [swtm_pkg::OUT_W-1:0]  rsp_mean;
   logic [swtm_pkg::OUT_W-1:0]  rsp_trimmed;
   logic [swtm_pkg::FILL_W-1:0] rsp_filled;

   // sequencer: accepts beats, steps the datapath, owns rsp_tvalid
   swtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // window ram, running sum, min/max scan, divider and output register
   swtm_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_size    (csr_tdata[swtm_pkg::CFG_W-1:0]),
      .req_sample  (req_tdata),
      .rsp_mean    (rsp_mean),
      .rsp_trimmed (rsp_trimmed),
      .rsp_filled  (rsp_filled)
   );

   assign rsp_tdata = {2'b00, rsp_filled, rsp_trimmed, rsp_mean};

   // one item at a time: an accepted beat closes the input for the next cycle
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while an item is in flight");

   // a config write and an item are never taken on the same edge
   a_csr_req_excl: assert property (@(posedge clock) disable iff (reset)
      !(csr_tvalid && csr_tready && req_tvalid && req_tready))
      else $error("config write and item accepted together");

   // with two or fewer filled slots the trimmed mean is the plain mean
   a_trim_small: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[37:32] <= 6'd2) |-> (rsp_tdata[31:16] == rsp_tdata[15:0]))
      else $error("trimmed mean differs from mean with few slots");

   // an empty window reports a zero mean
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[37:32] == 6'd0) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("nonzero mean from an empty window");

endmodule

// ===== tb/sv/tb_sliding_window_trimmed_mean_core.sv =====
module tb_sliding_window_trimmed_mean_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_MAX    = swtm_pkg::WINDOW_MAX_DEF;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;     // beyond the worst item latency
   localparam int PHASE_ITEMS   = 120;
   localparam int HOLD_AT       = 400;     // rsp beats before the long receiver hold-off
   localparam int HOLD_CYCLES   = 600;
   localparam int CALM_FROM     = 900;     // beat window with no idling on either side
   localparam int CALM_TO       = 1200;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic        kind;
      logic [15:0] sample;
   } window_item_type;

   typedef struct packed {
      logic [15:0] mean;
      logic [15:0] trimmed;
      logic [5:0]  filled;
   } window_means_type;

   // dut ports, the driven ones known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] sample
   logic        req_tuser  = swtm_pkg::KIND_SAMPLE;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // [15:0] mean, [31:16] trimmed_mean, [37:32] filled
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata  = '0;   // [5:0] window_size

   sliding_window_trimmed_mean_core #(
      .WINDOW_MAX (WINDOW_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // window predictor: own copy of the slots, the sum and the counters
   // ---------------------------------------------------------------
   logic [15:0] win_store [WINDOW_MAX];
   logic [20:0] win_sum  = '0;
   logic [5:0]  win_fill = '0;
   logic [5:0]  win_pos  = '0;
   logic [5:0]  win_size = 6'(swtm_pkg::WINDOW_SIZE_RESET);

   window_item_type  pending_samples [$];   // items not yet offered on req
   window_means_type pending_means [$];     // expected rsp beats, oldest first

   function automatic void empty_window();
      foreach (win_store[i]) win_store[i] = '0;
      win_sum  = '0;
      win_fill = '0;
      win_pos  = '0;
   endfunction

   // half-up rounding: (2n + d) / 2d, clamped to 16 bits
   function automatic logic [15:0] rounded_mean(logic [20:0] total, logic [5:0] count);
      logic [23:0] num;
      logic [23:0] quo;
      num = {2'b00, total, 1'b0} + 24'(count);
      quo = num / {17'd0, count, 1'b0};
      return (quo > 24'd65535) ? 16'hFFFF : quo[15:0];
   endfunction

   task automatic advance_window(input window_item_type item);
      logic [5:0]       span;
      logic [15:0]      lo;
      logic [15:0]      hi;
      window_means_type want;
      want = '0;
      if (item.kind == swtm_pkg::KIND_CLEAR) begin
         empty_window();
      end else begin
         // size 0 acts as one slot, anything above the store is cut back to it
         span = (win_size == 6'd0) ? 6'd1 :
                (win_size > 6'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : win_size;
         if (win_pos >= span) win_pos = '0;
         if (win_fill > span) win_fill = span;
         win_sum = win_sum - 21'(win_store[win_pos]) + 21'(item.sample);
         win_store[win_pos] = item.sample;
         win_pos = win_pos + 6'd1;
         if (win_pos >= span) win_pos = '0;
         if (win_fill < span) win_fill = win_fill + 6'd1;
         want.mean    = rounded_mean(win_sum, win_fill);
         want.trimmed = want.mean;
         want.filled  = win_fill;
         // drop one smallest and one largest filled slot once three are present
         if (win_fill > 6'd2) begin
            lo = win_store[0];
            hi = win_store[0];
            for (int i = 1; i < win_fill; i++) begin
               if (win_store[i] < lo) lo = win_store[i];
               if (win_store[i] > hi) hi = win_store[i];
            end
            want.trimmed = rounded_mean(win_sum - 21'(lo) - 21'(hi), win_fill - 6'd2);
         end
      end
      pending_means.push_back(want);
   endtask

   // ---------------------------------------------------------------
   // scoreboard bookkeeping
   // ---------------------------------------------------------------
   int mismatches = 0;
   int cycles     = 0;
   int req_count  = 0;
   int rsp_count  = 0;
   logic req_beat = 1'b0;   // a req beat went through at the last rising edge

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch at rsp beat %0d: %s", rsp_count, msg);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endfunction

   // monitor and predictor share the rising edge: results are checked before the
   // new item's expectation is queued, both sampled before the dut updates
   always @(posedge clock) begin
      window_means_type want;
      if (!reset) begin
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            req_beat <= req_tvalid && req_tready;
            if (rsp_tvalid && rsp_tready) begin
               rsp_count++;
               if (pending_means.size() == 0) begin
                  flag_mismatch($sformatf("unexpected result %h", rsp_tdata));
               end else begin
                  want = pending_means.pop_front();
                  check_field("mean", want.mean, rsp_tdata[15:0]);
                  check_field("trimmed_mean", want.trimmed, rsp_tdata[31:16]);
                  check_field("filled", want.filled, rsp_tdata[37:32]);
               end
            end
            if (req_tvalid && req_tready) begin
               req_count++;
               advance_window({req_tuser, req_tdata});
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // req driver: one new beat per handshake, random gaps except in the calm window
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      window_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat) begin
         if (pending_samples.size() != 0 &&
             ((req_count >= CALM_FROM && req_count < CALM_TO) || $urandom_range(99) >= 10)) begin
            next_item   = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.kind;
            req_tdata  <= next_item.sample;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // rsp receiver: random stalls, one long hold-off that backs the core up
   // ---------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (rsp_count >= CALM_FROM && rsp_count < CALM_TO) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 10);
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   // opening run at the reset window of 8: clear on empty, field extremes,
   // two-slot rounding at half, ties, wrap past the window, clear with data
   window_item_type opening [22] = '{
      {swtm_pkg::KIND_CLEAR,  16'h0000}, {swtm_pkg::KIND_SAMPLE, 16'h0000},
      {swtm_pkg::KIND_SAMPLE, 16'hFFFF}, {swtm_pkg::KIND_SAMPLE, 16'h0001},
      {swtm_pkg::KIND_SAMPLE, 16'hFFFE}, {swtm_pkg::KIND_SAMPLE, 16'h5555},
      {swtm_pkg::KIND_SAMPLE, 16'hAAAA}, {swtm_pkg::KIND_SAMPLE, 16'hFFFF},
      {swtm_pkg::KIND_SAMPLE, 16'hFFFF}, {swtm_pkg::KIND_SAMPLE, 16'h0000},
      {swtm_pkg::KIND_SAMPLE, 16'h3039}, {swtm_pkg::KIND_CLEAR,  16'hFFFF},
      {swtm_pkg::KIND_SAMPLE, 16'h0001}, {swtm_pkg::KIND_SAMPLE, 16'h0002},
      {swtm_pkg::KIND_SAMPLE, 16'h0002}, {swtm_pkg::KIND_SAMPLE, 16'hFFFF},
      {swtm_pkg::KIND_SAMPLE, 16'hFFFF}, {swtm_pkg::KIND_SAMPLE, 16'hFFFF},
      {swtm_pkg::KIND_CLEAR,  16'h1234}, {swtm_pkg::KIND_SAMPLE, 16'h0000},
      {swtm_pkg::KIND_SAMPLE, 16'h0000}, {swtm_pkg::KIND_SAMPLE, 16'h0000}
   };

   // window settings: extremes, zero, oversize values and a few in between
   logic [5:0] window_sizes [$] = '{6'd1, 6'd2, 6'd3, 6'd32, 6'd0, 6'd63,
                                    6'd33, 6'd5, 6'd17, 6'd8, 6'd4, 6'd31};

   // mostly full-range values, with extremes and a narrow band for ties
   function automatic logic [15:0] pick_sample(logic [15:0] band);
      case ($urandom_range(19))
         0, 1:          return 16'h0000;
         2, 3:          return 16'hFFFF;
         4, 5, 6, 7, 8: return band + 16'($urandom_range(3));
         default:       return 16'($urandom_range(65535));
      endcase
   endfunction

   // everything offered, taken and answered, then the core left to go quiet
   task automatic settle();
      while (pending_samples.size() != 0 || req_tvalid || pending_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [15:0] band;
      empty_window();
      window_sizes.push_back(6'($urandom_range(63)));
      window_sizes.push_back(6'($urandom_range(63)));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i]) pending_samples.push_back(opening[i]);

      foreach (window_sizes[p]) begin
         settle();

         // window size write, only with the core idle; it also empties the window
         @(negedge clock);
         csr_tvalid <= 1'b1;
         csr_tdata  <= {2'b00, window_sizes[p]};
         do @(posedge clock); while (!csr_tready);
         win_size = window_sizes[p];
         empty_window();
         @(negedge clock);
         csr_tvalid <= 1'b0;

         // long sample runs with an occasional clear so full windows wrap often
         band = 16'($urandom_range(65532));
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(59) == 0)
               pending_samples.push_back({swtm_pkg::KIND_CLEAR, 16'($urandom_range(65535))});
            else
               pending_samples.push_back({swtm_pkg::KIND_SAMPLE, pick_sample(band)});
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
